/* rtl/krt_pkg.sv */
// Package for the keyed record table: status codes, operation codes and record types.
// Used by every module of the block; depends on nothing.
`default_nettype none
package krt_pkg;
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_DEL  = 2'd1;
  localparam logic [1:0] OP_FIND = 2'd2;
  localparam logic [1:0] OP_LIST = 2'd3;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_EMPTY_KEY = 3'd2;
  localparam logic [2:0] ST_RECORD    = 3'd3;
  localparam logic [2:0] ST_DONE      = 3'd4;

  typedef struct packed {
    logic [7:0]  high;
    logic [63:0] low;
  } text_t;

  typedef struct packed {
    text_t phone;
    text_t surname;
    text_t key;
  } record_t;

  // Clears every character after the first zero character.
  function automatic text_t terminate(input text_t t);
    text_t r;
    logic  seen;
    r = t;
    seen = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (t.low[8*i +: 8] == 8'd0) seen = 1'b1;
      if (seen) r.low[8*i +: 8] = 8'd0;
    end
    if (seen) r.high = 8'd0;
    return r;
  endfunction
endpackage
`default_nettype wire

/* rtl/krt_cell.sv */
// One slot cell of the record table: holds a record, written by add and cleared by delete.
// Depends on krt_pkg.
`default_nettype none
module krt_cell (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire krt_pkg::record_t wr_rec,
  input  wire logic             clr_en,
  output krt_pkg::record_t      rec,
  output logic                  occupied
);
  krt_pkg::record_t rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r <= '0;
    end else begin
      if (wr_en) begin
        rec_r <= wr_rec;
      end else if (clr_en) begin
        rec_r <= '0;
      end
    end
  end

  assign rec      = rec_r;
  assign occupied = (rec_r.key != '0);
endmodule
`default_nettype wire

/* rtl/keyed_record_table_unit.sv */
// Top level of the keyed record table: an array of slot cells, an index scanner and output register.
// Depends on krt_pkg and krt_cell.
//
// channel  direction  contents
// in_      slave      operation in tuser; key, surname, phone in tdata
// out_     master     status, slot, record, count in tdata; last in tlast
//
// Add writes the lowest free slot and registers its result on acceptance. Delete, find and list
// walk the cells in slot order, one slot per cycle while not held, then emit the done item.
// The scan holds while an emitted record waits at the output register.
// Reset clears every slot and the occupied count.
`default_nettype none
module keyed_record_table_unit #(
  parameter int DEPTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [215:0] in_tdata, // key_low, key_high, surname_low, surname_high,
                                      // phone_low, phone_high
  input  wire logic [1:0]   in_tuser, // operation
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [231:0]      out_tdata, // status, slot, out_key_low, out_key_high,
                                       // out_surname_low, out_surname_high,
                                       // out_phone_low, out_phone_high, match_count, pad
  output logic              out_tlast
);
  localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [1:0]          op_r;
  krt_pkg::text_t      key_r;
  logic [SW-1:0]       idx_r;
  logic [5:0]          cnt_r;
  logic [5:0]          occ_r;
  logic                ov_r, ov_nxt;
  logic [231:0]        od_r, od_nxt;
  logic                ol_r, ol_nxt;

  logic [DEPTH-1:0]    wr_en;
  logic [DEPTH-1:0]    clr_en;
  logic [DEPTH-1:0]    occ;
  krt_pkg::record_t    recs [DEPTH];
  krt_pkg::record_t    new_rec;

  krt_pkg::text_t      in_key;
  logic                key_empty;
  logic                free_found;
  logic [SW-1:0]       free_idx;
  logic                out_free;
  logic                start_scan;
  logic                step;
  logic                hit;
  krt_pkg::record_t    cur;

  assign in_key    = krt_pkg::terminate(in_tdata[71:0]);
  assign key_empty = (in_key == '0);
  assign new_rec   = '{phone: krt_pkg::terminate(in_tdata[215:144]),
                       surname: krt_pkg::terminate(in_tdata[143:72]), key: in_key};
  assign out_free  = !ov_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign start_scan = in_tvalid && in_tready && (in_tuser != krt_pkg::OP_ADD);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!occ[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  assign cur  = recs[idx_r];
  assign hit  = (op_r == krt_pkg::OP_LIST) ? occ[idx_r]
                : ((key_r != '0) && (cur.key == key_r));
  // Delete never emits records; find and list stall on a hit until the output is free.
  assign step = (state_r == S_SCAN) && (!hit || (op_r == krt_pkg::OP_DEL) || out_free);

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      assign wr_en[g]  = in_tvalid && in_tready && (in_tuser == krt_pkg::OP_ADD) &&
                         !key_empty && free_found && (occ_r < 6'(DEPTH)) &&
                         (free_idx == SW'(g));
      assign clr_en[g] = step && hit && (op_r == krt_pkg::OP_DEL) && (idx_r == SW'(g));
      krt_cell u_cell (
        .clk(clk), .rst_n(rst_n),
        .wr_en(wr_en[g]), .wr_rec(new_rec), .clr_en(clr_en[g]),
        .rec(recs[g]), .occupied(occ[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start_scan) state_nxt = S_SCAN;
      S_SCAN: if (step && (idx_r == SW'(DEPTH - 1))) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    ol_nxt = ol_r;
    od_nxt = od_r;
    if (out_tvalid && out_tready) ov_nxt = 1'b0;
    if (in_tvalid && in_tready && (in_tuser == krt_pkg::OP_ADD)) begin
      ov_nxt = 1'b1;
      ol_nxt = 1'b1;
      od_nxt = '0;
      if (key_empty) begin
        od_nxt[2:0] = krt_pkg::ST_EMPTY_KEY;
      end else if (wr_en != '0) begin
        od_nxt[2:0] = krt_pkg::ST_ADDED;
        od_nxt[7:3] = 5'(free_idx);
      end else begin
        od_nxt[2:0] = krt_pkg::ST_FULL;
      end
    end
    if (step && hit && (op_r != krt_pkg::OP_DEL)) begin
      ov_nxt        = 1'b1;
      ol_nxt        = 1'b0;
      od_nxt        = '0;
      od_nxt[2:0]   = krt_pkg::ST_RECORD;
      od_nxt[7:3]   = 5'(idx_r);
      od_nxt[223:8] = cur;
    end
    if ((state_r == S_DONE) && out_free) begin
      ov_nxt          = 1'b1;
      ol_nxt          = 1'b1;
      od_nxt          = '0;
      od_nxt[2:0]     = krt_pkg::ST_DONE;
      od_nxt[229:224] = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      ol_r    <= 1'b0;
      od_r    <= '0;
      occ_r   <= '0;
      idx_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      ol_r    <= ol_nxt;
      od_r    <= od_nxt;
      if (in_tvalid && in_tready) begin
        op_r  <= in_tuser;
        key_r <= in_key;
        idx_r <= '0;
        cnt_r <= '0;
        if (wr_en != '0) occ_r <= occ_r + 6'd1;
      end
      if (step) begin
        idx_r <= idx_r + SW'(1);
        if (hit) begin
          cnt_r <= cnt_r + 6'd1;
          if ((op_r == krt_pkg::OP_DEL) && (occ_r != 6'd0)) occ_r <= occ_r - 6'd1;
        end
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;
endmodule
`default_nettype wire

/* verif/tb_keyed_record_table_unit.sv */
// Self-checking testbench for keyed_record_table_unit: random add, delete, find and list
// items against a behavioral table, with random stalls on both stream channels.
// Depends on krt_pkg and the RTL of the block.
`default_nettype none
module tb_keyed_record_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  phone_high;
    logic [63:0] phone_low;
    logic [7:0]  surname_high;
    logic [63:0] surname_low;
    logic [7:0]  key_high;
    logic [63:0] key_low;
  } request_t;

  typedef struct packed {
    logic        last;
    logic [5:0]  count;
    logic [7:0]  phone_high;
    logic [63:0] phone_low;
    logic [7:0]  surname_high;
    logic [63:0] surname_low;
    logic [7:0]  key_high;
    logic [63:0] key_low;
    logic [4:0]  slot;
    logic [2:0]  status;
  } answer_t;

  localparam int NSLOT = 32;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [215:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [231:0] out_tdata;
  logic out_tlast;

  keyed_record_table_unit #(.DEPTH(NSLOT)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always #6 clk = ~clk;

  krt_pkg::record_t table_mirror [NSLOT];
  int       occupied;
  request_t pending_requests[$];
  answer_t  expected_answers[$];
  int       mismatches = 0;
  int       idle_cycles = 0;
  bit       stimulus_done = 1'b0;
  bit       drain_request = 1'b0;
  bit       hold_off_request = 1'b0;
  int       send_gap = 0;
  int       recv_gap = 0;
  bit       timed_out = 1'b0;
  logic [63:0] key_pool_low[8];
  logic [7:0]  key_pool_high[8];

  function automatic krt_pkg::text_t clip(logic [63:0] lo, logic [7:0] hi);
    krt_pkg::text_t t;
    bit seen;
    t.low = lo;
    t.high = hi;
    seen = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (lo[8*i +: 8] == 8'd0) seen = 1'b1;
      if (seen) t.low[8*i +: 8] = 8'd0;
    end
    if (seen) t.high = 8'd0;
    return t;
  endfunction

  function automatic answer_t blank_answer(logic [2:0] st);
    answer_t a;
    a = '0;
    a.status = st;
    return a;
  endfunction

  // Applies one operation to the mirror table and queues the answers it causes.
  function automatic void apply_operation(request_t r);
    krt_pkg::text_t key;
    answer_t a;
    int hit_count;
    int free_slot;
    key = clip(r.key_low, r.key_high);
    if (r.op == krt_pkg::OP_ADD) begin
      if (key == '0) begin
        a = blank_answer(krt_pkg::ST_EMPTY_KEY);
      end else begin
        free_slot = -1;
        if (occupied < NSLOT) begin
          for (int i = 0; i < NSLOT; i++) begin
            if (free_slot < 0 && table_mirror[i].key == '0) free_slot = i;
          end
        end
        if (free_slot < 0) begin
          a = blank_answer(krt_pkg::ST_FULL);
        end else begin
          table_mirror[free_slot].key = key;
          table_mirror[free_slot].surname = clip(r.surname_low, r.surname_high);
          table_mirror[free_slot].phone = clip(r.phone_low, r.phone_high);
          occupied++;
          a = blank_answer(krt_pkg::ST_ADDED);
          a.slot = free_slot[4:0];
        end
      end
      a.last = 1'b1;
      expected_answers.push_back(a);
      return;
    end
    hit_count = 0;
    for (int i = 0; i < NSLOT; i++) begin
      bit hit;
      if (r.op == krt_pkg::OP_LIST) hit = table_mirror[i].key != '0;
      else hit = key != '0 && table_mirror[i].key == key;
      if (hit) begin
        hit_count++;
        if (r.op == krt_pkg::OP_DEL) begin
          table_mirror[i] = '0;
          if (occupied > 0) occupied--;
        end else begin
          a = blank_answer(krt_pkg::ST_RECORD);
          a.slot = i[4:0];
          a.key_low = table_mirror[i].key.low;
          a.key_high = table_mirror[i].key.high;
          a.surname_low = table_mirror[i].surname.low;
          a.surname_high = table_mirror[i].surname.high;
          a.phone_low = table_mirror[i].phone.low;
          a.phone_high = table_mirror[i].phone.high;
          expected_answers.push_back(a);
        end
      end
    end
    a = blank_answer(krt_pkg::ST_DONE);
    a.count = hit_count[5:0];
    a.last = 1'b1;
    expected_answers.push_back(a);
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Random text: occasional early terminator, occasionally all ones, random bytes otherwise.
  function automatic logic [71:0] random_text();
    logic [71:0] v;
    int cut;
    v = 72'({$urandom, $urandom, $urandom});
    case ($urandom_range(0, 3))
      0: begin
        cut = $urandom_range(1, 8);
        v[8*cut +: 8] = 8'd0;
      end
      1: v = '1;
      default: ;
    endcase
    return v;
  endfunction

  function automatic request_t make_request(logic [1:0] op, bit pooled);
    request_t r;
    logic [71:0] t;
    int k;
    t = random_text();
    {r.key_high, r.key_low} = t;
    if (pooled) begin
      k = $urandom_range(0, 7);
      r.key_low = key_pool_low[k];
      r.key_high = key_pool_high[k];
    end
    t = random_text();
    {r.surname_high, r.surname_low} = t;
    t = random_text();
    {r.phone_high, r.phone_low} = t;
    r.op = op;
    return r;
  endfunction

  // Sender: offers items from the pending queue; predicts on acceptance.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        apply_operation(pending_requests.pop_front());
        send_gap = pick_gap();
      end
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_requests.size() > 0 && !(drain_request && expected_answers.size() > 0))
      begin
        in_tvalid <= 1'b1;
        in_tdata <= {pending_requests[0].phone_high, pending_requests[0].phone_low,
                     pending_requests[0].surname_high, pending_requests[0].surname_low,
                     pending_requests[0].key_high, pending_requests[0].key_low};
        in_tuser <= pending_requests[0].op;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, one long hold-off on request.
  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = '0;
        got.status = out_tdata[2:0];
        got.slot = out_tdata[7:3];
        got.key_low = out_tdata[71:8];
        got.key_high = out_tdata[79:72];
        got.surname_low = out_tdata[143:80];
        got.surname_high = out_tdata[151:144];
        got.phone_low = out_tdata[215:152];
        got.phone_high = out_tdata[223:216];
        got.count = out_tdata[229:224];
        got.last = out_tlast;
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result item %h", got);
        end else begin
          want = expected_answers.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("Result mismatch: expected %h, got %h", want, got);
          end
        end
      end
      if (hold_off_request) begin
        recv_gap = 400;
        hold_off_request = 1'b0;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 9) == 0) recv_gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > 20000 && !timed_out && !stimulus_done) begin
      timed_out = 1'b1;
      $display("keyed_record_table_unit regression: fail");
      $finish;
    end
  end

  initial begin
    request_t r;
    int p;
    for (int i = 0; i < NSLOT; i++) table_mirror[i] = '0;
    occupied = 0;
    for (int k = 0; k < 8; k++) begin
      {key_pool_high[k], key_pool_low[k]} = random_text();
      if (key_pool_low[k][7:0] == 8'd0) key_pool_low[k][7:0] = 8'(8'h41 + k);
    end
    key_pool_low[0] = 64'h0000_0000_0000_0041;
    key_pool_high[0] = 8'h00;
    key_pool_low[1] = 64'hFFFF_FFFF_FFFF_FFFF;
    key_pool_high[1] = 8'hFF;
    key_pool_low[2] = 64'h1234_0000_0000_0041;
    key_pool_high[2] = 8'h77;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty keys, terminator handling, each operation, all-ones fields.
    r = make_request(krt_pkg::OP_LIST, 1'b0);
    pending_requests.push_back(r);
    r = make_request(krt_pkg::OP_ADD, 1'b0);
    r.key_low = '0;
    r.key_high = 8'hFF;
    pending_requests.push_back(r);
    r.op = krt_pkg::OP_DEL;
    pending_requests.push_back(r);
    r.op = krt_pkg::OP_FIND;
    pending_requests.push_back(r);
    for (int k = 0; k < 3; k++) begin
      r = make_request(krt_pkg::OP_ADD, 1'b0);
      r.key_low = key_pool_low[k];
      r.key_high = key_pool_high[k];
      r.surname_low = '1;
      r.surname_high = '1;
      r.phone_low = 64'h00FF_FFFF_FFFF_FF31;
      r.phone_high = 8'hAB;
      pending_requests.push_back(r);
    end
    r = make_request(krt_pkg::OP_ADD, 1'b0);
    r.key_low = 64'h0000_0000_0000_0041;
    r.key_high = 8'h00;
    pending_requests.push_back(r);
    r.op = krt_pkg::OP_FIND;
    pending_requests.push_back(r);
    pending_requests.push_back(make_request(krt_pkg::OP_LIST, 1'b0));
    r.op = krt_pkg::OP_DEL;
    pending_requests.push_back(r);
    pending_requests.push_back(make_request(krt_pkg::OP_LIST, 1'b0));

    // Fill to full and beyond while the receiver holds off.
    for (int i = 0; i < 36; i++) pending_requests.push_back(make_request(krt_pkg::OP_ADD, 1'b1));
    pending_requests.push_back(make_request(krt_pkg::OP_LIST, 1'b0));
    wait (pending_requests.size() < 30);
    hold_off_request = 1'b1;
    wait (pending_requests.size() == 0);

    drain_request = 1'b1;
    for (int k = 0; k < 8; k++) pending_requests.push_back(make_request(krt_pkg::OP_DEL, 1'b1));
    wait (pending_requests.size() == 0 && expected_answers.size() == 0);
    drain_request = 1'b0;

    // Random: mostly pooled keys so that matches happen.
    for (int i = 0; i < 320; i++) begin
      p = $urandom_range(0, 99);
      if (p < 50) r = make_request(krt_pkg::OP_ADD, $urandom_range(0, 4) != 0);
      else if (p < 65) r = make_request(krt_pkg::OP_DEL, $urandom_range(0, 4) != 0);
      else if (p < 87) r = make_request(krt_pkg::OP_FIND, $urandom_range(0, 4) != 0);
      else r = make_request(krt_pkg::OP_LIST, 1'b0);
      pending_requests.push_back(r);
      if (i == 200) begin
        wait (pending_requests.size() == 0);
        drain_request = 1'b1;
        wait (expected_answers.size() == 0);
        drain_request = 1'b0;
      end
    end
    wait (pending_requests.size() == 0 && expected_answers.size() == 0);
    repeat (100) @(posedge clk);
    stimulus_done = 1'b1;
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("keyed_record_table_unit regression: pass");
    end else begin
      $display("keyed_record_table_unit regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
